/* src/free_list_handle_allocator_unit_assert.svh */
// ---------------------------------------------------------------------------
// free list handle allocator assertion macros
// shared property forms used by the allocator rtl
// ---------------------------------------------------------------------------
`ifndef FREE_LIST_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`define FREE_LIST_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define FLA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication under synchronous active-low reset
`define FLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

/* src/fla_pkg.sv */
// ---------------------------------------------------------------------------
// fla_pkg
// types and constants of the free list handle allocator
// ---------------------------------------------------------------------------
package fla_pkg;

    localparam int HANDLE_W  = 4;
    localparam int COUNT_W   = 5;
    localparam int ERR_W     = 8;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 32;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_command;

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    // result item, highest field first
    typedef struct packed {
        logic [OUT_DATA_W-27:0] pad;
        logic [ERR_W-1:0]       underflow_total;
        logic [ERR_W-1:0]       overflow_total;
        logic [COUNT_W-1:0]     free_count;
        logic                   ok;
        logic [HANDLE_W-1:0]    handle_out;
    } t_result;

endpackage

/* src/fla_ram.sv */
// ---------------------------------------------------------------------------
// fla_ram
// generic single-write single-read ram with registered read data
// ---------------------------------------------------------------------------
module fla_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/free_list_handle_allocator_unit.sv */
// ---------------------------------------------------------------------------
// free_list_handle_allocator_unit
// free list of record handles held in a ring memory
// ---------------------------------------------------------------------------
// Each request (alloc or free) is accepted while the unit is idle; a
// successful one reads or writes the ring memory at that edge, and in
// ST_BUSY the result is built from the registered ram read data and loaded
// into the result register, so no new request is taken until then. After
// reset the ring is full and holds handles 0 to RECORD_COUNT-1 in order; a
// per-entry valid bit makes an entry that was never written read as its own
// index, so no clearing pass is needed. The result register lets the next
// request in while a result still waits downstream.
module free_list_handle_allocator_unit #(
    parameter int RECORD_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] handle_in, [7:4] zero
    input  logic [fla_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] handle_out, [4] ok, [9:5] free_count, [17:10] overflow_total,
    // [25:18] underflow_total, [31:26] zero
    output logic [fla_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import fla_pkg::*;

    localparam int PW = $clog2(RECORD_COUNT);
    localparam int CW = $clog2(RECORD_COUNT + 1);
    localparam logic [PW-1:0] LAST_POS   = PW'(RECORD_COUNT - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(RECORD_COUNT);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    t_state                r_state;
    logic [PW-1:0]         r_rd_pos;
    logic [PW-1:0]         r_wr_pos;
    logic [CW-1:0]         r_count;
    logic [ERR_W-1:0]      r_ovf;
    logic [ERR_W-1:0]      r_unf;
    logic [RECORD_COUNT-1:0] r_valid;
    logic                  r_res_alloc;
    logic                  r_res_ok;
    logic                  r_rd_hit;
    logic [PW-1:0]         r_rd_idx;
    logic                  r_m_valid;
    t_result               r_m_data;

    logic                  accept;
    logic                  load_result;
    logic                  ring_empty;
    logic                  ring_full;
    logic                  is_alloc;
    logic                  alloc_ok;
    logic                  free_ok;
    logic [HANDLE_W-1:0]   ram_q;
    logic [HANDLE_W-1:0]   rd_handle;
    logic [PW+HANDLE_W-1:0] idx_ext;
    logic [CW+COUNT_W-1:0] count_ext;
    t_result               n_result;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign load_result   = (r_state == ST_BUSY) & (~r_m_valid | m_axis_tready);
    assign ring_empty    = (r_count == '0);
    assign ring_full     = (r_count == FULL_COUNT);
    assign is_alloc      = (t_command'(s_axis_tuser) == CMD_ALLOC);
    assign alloc_ok      = is_alloc & ~ring_empty;
    assign free_ok       = ~is_alloc & ~ring_full;

    fla_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (RECORD_COUNT)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (accept & free_ok),
        .i_wr_addr (r_wr_pos),
        .i_wr_data (s_axis_tdata[HANDLE_W-1:0]),
        .i_rd_en   (accept & alloc_ok),
        .i_rd_addr (r_rd_pos),
        .o_rd_data (ram_q)
    );

    // an entry never written holds its own index, cut to the handle width
    assign idx_ext   = {{HANDLE_W{1'b0}}, r_rd_idx};
    assign rd_handle = r_rd_hit ? ram_q : idx_ext[HANDLE_W-1:0];
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    always_comb begin
        n_result                 = '0;
        n_result.handle_out      = (r_res_alloc & r_res_ok) ? rd_handle : '0;
        n_result.ok              = r_res_ok;
        n_result.free_count      = count_ext[COUNT_W-1:0];
        n_result.overflow_total  = r_ovf;
        n_result.underflow_total = r_unf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_pos  <= '0;
            r_wr_pos  <= '0;
            r_count   <= FULL_COUNT;
            r_ovf     <= '0;
            r_unf     <= '0;
            r_valid   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (load_result) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_res_alloc <= is_alloc;
                        r_res_ok    <= alloc_ok | free_ok;
                        r_rd_hit    <= r_valid[r_rd_pos];
                        r_rd_idx    <= r_rd_pos;
                        if (alloc_ok) begin
                            r_rd_pos <= (r_rd_pos == LAST_POS) ? '0 : r_rd_pos + 1'b1;
                            r_count  <= r_count - 1'b1;
                        end else if (free_ok) begin
                            r_valid[r_wr_pos] <= 1'b1;
                            r_wr_pos <= (r_wr_pos == LAST_POS) ? '0 : r_wr_pos + 1'b1;
                            r_count  <= r_count + 1'b1;
                        end else if (is_alloc) begin
                            if (r_unf != ERR_MAX) begin
                                r_unf <= r_unf + 1'b1;
                            end
                        end else begin
                            if (r_ovf != ERR_MAX) begin
                                r_ovf <= r_ovf + 1'b1;
                            end
                        end
                        r_state <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    // wait here until the result register is free
                    if (load_result) begin
                        r_m_data <= n_result;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `include "free_list_handle_allocator_unit_assert.svh"

    `FLA_ASSERT_SAME(a_no_accept_busy, i_clk, i_rst_n, r_state == ST_BUSY, !s_axis_tready)
    `FLA_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_COUNT)
    `FLA_ASSERT_NEXT(a_free_grows, i_clk, i_rst_n, accept && free_ok, r_count == $past(r_count) + 1'b1)
    `FLA_ASSERT_NEXT(a_alloc_shrinks, i_clk, i_rst_n, accept && alloc_ok, r_count == $past(r_count) - 1'b1)
    `FLA_ASSERT_SAME(a_fail_zero_handle, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[4], m_axis_tdata[3:0] == '0)

endmodule

/* dv/tb_free_list_handle_allocator_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_free_list_handle_allocator_unit
// checks the handle allocator against a cycle-free model of its free ring:
// directed cases (free on a full ring, in-order drain, alloc on an empty ring,
// duplicate frees), biased random alloc/free bursts, counter saturation and a
// run with no idling; the others run with random gaps and stalls on both streams
// ---------------------------------------------------------------------------
module tb_free_list_handle_allocator_unit;

    import fla_pkg::*;

    localparam int RECORD_COUNT = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int GAP_PERCENT  = 24;
    localparam int TAIL_CYCLES  = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [3:0] handle_in, [7:4] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] command
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [3:0] handle_out, [4] ok, [9:5] free_count, [17:10] overflow_total,
    // [25:18] underflow_total, [31:26] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    free_list_handle_allocator_unit #(
        .RECORD_COUNT(RECORD_COUNT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // free ring as the allocator should hold it; positions wrap at 16 by width
    logic [HANDLE_W-1:0] ring_handles [RECORD_COUNT];
    logic [HANDLE_W-1:0] rd_pos;
    logic [HANDLE_W-1:0] wr_pos;
    logic                ring_is_full;
    logic [ERR_W-1:0]    rejected_frees;
    logic [ERR_W-1:0]    rejected_allocs;

    t_result replies_due [$];
    int      fail_count = 0;
    bit      src_gaps_on = 1'b1;
    bit      sink_stalls_on = 1'b1;

    function automatic t_result apply_request(t_command cmd, logic [HANDLE_W-1:0] handle);
        t_result r;
        r = '0;
        if (cmd == CMD_ALLOC) begin
            if (!ring_is_full && rd_pos == wr_pos) begin
                if (rejected_allocs != ERR_MAX) rejected_allocs++;
            end else begin
                ring_is_full = 1'b0;
                r.handle_out = ring_handles[rd_pos];
                rd_pos++;
                r.ok = 1'b1;
            end
        end else begin
            if (ring_is_full) begin
                if (rejected_frees != ERR_MAX) rejected_frees++;
            end else begin
                ring_handles[wr_pos] = handle;
                wr_pos++;
                if (wr_pos == rd_pos) ring_is_full = 1'b1;
                r.ok = 1'b1;
            end
        end
        r.free_count      = ring_is_full ? COUNT_W'(RECORD_COUNT)
                                         : COUNT_W'(HANDLE_W'(wr_pos - rd_pos));
        r.overflow_total  = rejected_frees;
        r.underflow_total = rejected_allocs;
        return r;
    endfunction

    // one item on the request stream, with a random gap in front of it
    task automatic send_request(t_command cmd, logic [HANDLE_W-1:0] handle);
        while (src_gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_DATA_W'(handle);
        do @(posedge i_clk); while (!s_axis_tready);
        replies_due.push_back(apply_request(cmd, handle));
    endtask

    // drop the request stream so the last item is not taken twice
    task automatic wait_replies_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= sink_stalls_on ? ($urandom_range(99) >= GAP_PERCENT) : 1'b1;
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        got = t_result'(m_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (replies_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected reply item: data=%h", m_axis_tdata);
            end else begin
                want = replies_due.pop_front();
                if (got.handle_out !== want.handle_out || got.ok !== want.ok ||
                    got.free_count !== want.free_count ||
                    got.overflow_total !== want.overflow_total ||
                    got.underflow_total !== want.underflow_total ||
                    got.pad !== want.pad) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"reply mismatch: handle %0d/%0d ok %0d/%0d free %0d/%0d ",
                                  "ovf %0d/%0d unf %0d/%0d pad %h/%h (exp/act)"},
                                 want.handle_out, got.handle_out, want.ok, got.ok,
                                 want.free_count, got.free_count,
                                 want.overflow_total, got.overflow_total,
                                 want.underflow_total, got.underflow_total,
                                 want.pad, got.pad);
                end
            end
        end
    end

    task automatic test_free_when_full_after_reset();
        send_request(CMD_FREE, 4'd0);
        send_request(CMD_FREE, 4'd15);
    endtask

    task automatic test_drain_in_order();
        for (int i = 0; i < RECORD_COUNT; i++)
            send_request(CMD_ALLOC, HANDLE_W'($urandom_range(15)));
    endtask

    task automatic test_alloc_when_empty();
        send_request(CMD_ALLOC, 4'd15);
        send_request(CMD_ALLOC, 4'd0);
    endtask

    task automatic test_duplicate_free();
        send_request(CMD_FREE, 4'd15);
        send_request(CMD_FREE, 4'd15);
        send_request(CMD_FREE, 4'd0);
        send_request(CMD_ALLOC, 4'd0);
        send_request(CMD_ALLOC, 4'd15);
    endtask

    // bursts leaning to alloc or to free push the ring to both ends
    task automatic test_random_mix(int n_items);
        int sent;
        int lean;
        int seg_len;
        int alloc_pct;
        sent = 0;
        while (sent < n_items) begin
            lean    = $urandom_range(2);
            seg_len = $urandom_range(48, 8);
            alloc_pct = (lean == 0) ? 50 : (lean == 1) ? 85 : 15;
            for (int i = 0; i < seg_len && sent < n_items; i++) begin
                send_request(($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE,
                             HANDLE_W'($urandom_range(15)));
                sent++;
            end
            if ($urandom_range(7) == 0) wait_replies_drained();
        end
    endtask

    task automatic test_pause_until_idle();
        for (int i = 0; i < 6; i++)
            send_request(t_command'($urandom_range(1)), HANDLE_W'($urandom_range(15)));
        wait_replies_drained();
        for (int i = 0; i < 6; i++)
            send_request(t_command'($urandom_range(1)), HANDLE_W'($urandom_range(15)));
    endtask

    // enough rejects of each kind to pin both counters at their ceiling
    task automatic test_counter_saturation();
        for (int i = 0; i < 280; i++)
            send_request(CMD_ALLOC, HANDLE_W'($urandom_range(15)));
        for (int i = 0; i < RECORD_COUNT + 280; i++)
            send_request(CMD_FREE, HANDLE_W'($urandom_range(15)));
    endtask

    task automatic test_back_to_back(int n_items);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_mix(n_items);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < RECORD_COUNT; i++) ring_handles[i] = HANDLE_W'(i);
        rd_pos          = '0;
        wr_pos          = '0;
        ring_is_full    = 1'b1;
        rejected_frees  = '0;
        rejected_allocs = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_free_when_full_after_reset();
        test_drain_in_order();
        test_alloc_when_empty();
        test_duplicate_free();
        test_pause_until_idle();
        test_random_mix(400);
        test_counter_saturation();
        test_back_to_back(200);
        test_random_mix(300);

        wait_replies_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/fla_pkg.sv
src/fla_ram.sv
src/free_list_handle_allocator_unit.sv
dv/tb_free_list_handle_allocator_unit.sv
